FILE: rtl/wvm_pkg.sv
// ----------------------------------------------------------------------------
// wvm_pkg
// Shared widths, codes and control types of the wavetable voice mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package wvm_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int TABLE_DEPTH = 4096;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);

  localparam int PHASE_W  = 28;
  localparam int LEN_W    = 13;
  localparam int GAIN_W   = 16;
  localparam int SAMPLE_W = 16;
  localparam int MIX_W    = 24;
  localparam int TADDR_W  = 12;
  localparam int ACTION_W = 2;
  localparam int CFG_W    = 28;
  localparam int CFG_IDX_W = 3;

  localparam int END_W = LEN_W + FRAC_BITS;
  localparam int CMP_W = (END_W > PHASE_W) ? END_W : PHASE_W;
  localparam int DIFF_W = SAMPLE_W + 1;
  localparam int PROD_W = DIFF_W + FRAC_BITS + 1;
  localparam int SCALED_W = GAIN_W + 1 + SAMPLE_W;
  localparam int SUM_W = SCALED_W + 1;

  localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_START = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_PHASE_INC  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_START = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_END   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_LEN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_EN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIX_GAIN   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INTERP_EN  = 3'd6;

  typedef struct packed {
    logic [PHASE_W-1:0] phase_increment;
    logic [PHASE_W-1:0] loop_start_phase;
    logic [PHASE_W-1:0] loop_end_phase;
    logic [LEN_W-1:0]   table_length;
    logic               loop_enable;
    logic [GAIN_W-1:0]  mix_gain;
    logic               interp_enable;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic start;
    logic tick;
    logic diff_en;
    logic interp_en;
    logic scale_en;
    logic out_en;
  } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/wvm_if.sv
// ----------------------------------------------------------------------------
// wvm_in_if / wvm_out_if
// Valid/ready channels for input items and mix results.
// ----------------------------------------------------------------------------
`default_nettype none

interface wvm_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [wvm_pkg::ACTION_W-1:0]          action;
  logic [wvm_pkg::TADDR_W-1:0]           table_address;
  logic signed [wvm_pkg::SAMPLE_W-1:0]   table_sample;
  logic signed [wvm_pkg::MIX_W-1:0]      mix_in;

  modport source (output valid, action, table_address, table_sample, mix_in, input ready);
  modport sink (input valid, action, table_address, table_sample, mix_in, output ready);
endinterface

interface wvm_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [wvm_pkg::MIX_W-1:0]  mix_out;
  logic                              playing;

  modport source (output valid, mix_out, playing, input ready);
  modport sink (input valid, mix_out, playing, output ready);
endinterface

`default_nettype wire

FILE: rtl/wvm_cfg_regs.sv
// ----------------------------------------------------------------------------
// wvm_cfg_regs
// Configuration register file, write only, indexed writes.
// ----------------------------------------------------------------------------
`default_nettype none

module wvm_cfg_regs (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [wvm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [wvm_pkg::CFG_W-1:0]         cfg_data,
  output wvm_pkg::cfg_t                          cfg
);

  wvm_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.phase_increment  <= wvm_pkg::PHASE_W'(65536);
      cfg_r.loop_start_phase <= '0;
      cfg_r.loop_end_phase   <= '0;
      cfg_r.table_length     <= wvm_pkg::LEN_W'(4096);
      cfg_r.loop_enable      <= 1'b0;
      cfg_r.mix_gain         <= wvm_pkg::GAIN_W'(32768);
      cfg_r.interp_enable    <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wvm_pkg::REG_PHASE_INC:  cfg_r.phase_increment  <= cfg_data[wvm_pkg::PHASE_W-1:0];
        wvm_pkg::REG_LOOP_START: cfg_r.loop_start_phase <= cfg_data[wvm_pkg::PHASE_W-1:0];
        wvm_pkg::REG_LOOP_END:   cfg_r.loop_end_phase   <= cfg_data[wvm_pkg::PHASE_W-1:0];
        wvm_pkg::REG_TABLE_LEN:  cfg_r.table_length     <= cfg_data[wvm_pkg::LEN_W-1:0];
        wvm_pkg::REG_LOOP_EN:    cfg_r.loop_enable      <= cfg_data[0];
        wvm_pkg::REG_MIX_GAIN:   cfg_r.mix_gain         <= cfg_data[wvm_pkg::GAIN_W-1:0];
        wvm_pkg::REG_INTERP_EN:  cfg_r.interp_enable    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

FILE: rtl/wvm_ctrl.sv
// ----------------------------------------------------------------------------
// wvm_ctrl
// Sequencer: accepts items, steps a tick through the datapath stages and
// owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module wvm_ctrl (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  input  wire logic [wvm_pkg::ACTION_W-1:0]    in_action,
  output      logic                            in_ready,
  output      logic                            out_valid,
  input  wire logic                            out_ready,
  output      wvm_pkg::cmd_t                   cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_INTERP,
    ST_SCALE,
    ST_MIX
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   in_fire;
  logic   out_free;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    cmd = '0;
    if (in_fire) begin
      unique case (in_action)
        wvm_pkg::ACT_LOAD:  cmd.load  = 1'b1;
        wvm_pkg::ACT_START: cmd.start = 1'b1;
        wvm_pkg::ACT_TICK:  cmd.tick  = 1'b1;
        default: ;
      endcase
    end
    cmd.diff_en   = (state_r == ST_READ);
    cmd.interp_en = (state_r == ST_INTERP);
    cmd.scale_en  = (state_r == ST_SCALE);
    cmd.out_en    = (state_r == ST_MIX) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.out_en) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (cmd.tick) begin
            state_r <= ST_READ;
          end
        end
        ST_READ:   state_r <= ST_INTERP;
        ST_INTERP: state_r <= ST_SCALE;
        ST_SCALE:  state_r <= ST_MIX;
        ST_MIX: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

FILE: rtl/wvm_datapath.sv
// ----------------------------------------------------------------------------
// wvm_datapath
// Phase accumulator, sample table, interpolation, gain and saturating mix.
// ----------------------------------------------------------------------------
`default_nettype none

module wvm_datapath (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire wvm_pkg::cfg_t                          cfg,
  input  wire wvm_pkg::cmd_t                          cmd,
  input  wire logic [wvm_pkg::TADDR_W-1:0]            table_address,
  input  wire logic signed [wvm_pkg::SAMPLE_W-1:0]    table_sample,
  input  wire logic signed [wvm_pkg::MIX_W-1:0]       mix_in,
  output      logic signed [wvm_pkg::MIX_W-1:0]       mix_out,
  output      logic                                   playing
);

  localparam int AW   = wvm_pkg::ADDR_W;
  localparam int FB   = wvm_pkg::FRAC_BITS;
  localparam int PW   = wvm_pkg::PHASE_W;
  localparam int SW   = wvm_pkg::SAMPLE_W;
  localparam int MW   = wvm_pkg::MIX_W;
  localparam int CW   = wvm_pkg::CMP_W;
  localparam int EW   = wvm_pkg::END_W;
  localparam int DW   = wvm_pkg::DIFF_W;
  localparam int PRW  = wvm_pkg::PROD_W;
  localparam int SCW  = wvm_pkg::SCALED_W;
  localparam int SUMW = wvm_pkg::SUM_W;
  localparam int AEXT = (wvm_pkg::TADDR_W > AW) ? wvm_pkg::TADDR_W : AW;

  localparam logic signed [SUMW-1:0] MIX_MAX = SUMW'(2**(MW-1) - 1);
  localparam logic signed [SUMW-1:0] MIX_MIN = -SUMW'(2**(MW-1));
  localparam logic [PRW-1:0] TRUNC_BIAS = {{(PRW-FB){1'b0}}, {FB{1'b1}}};

  logic signed [SW-1:0] table_mem [wvm_pkg::TABLE_DEPTH];

  // Phase and voice state
  logic [PW-1:0] phase_r;
  logic          active_r;

  // Tick pipeline
  logic signed [SW-1:0]  rd0_r, rd1_r;
  logic [FB-1:0]         frac_r;
  logic                  tick_active_r;
  logic signed [MW-1:0]  mix_r;
  logic signed [PRW-1:0] prod_r;
  logic signed [SW-1:0]  v_r;
  logic signed [SW-1:0]  vi_r;
  logic signed [SCW-1:0] scaled_r;
  logic signed [MW-1:0]  mix_out_r;
  logic                  playing_r;

  logic [wvm_pkg::LEN_W-1:0] len_eff;
  logic [EW-1:0]             end_phase;
  logic                      at_end;
  logic                      wrap;
  logic                      active_tick;
  logic [PW-1:0]             eff_phase;
  logic [PW-1:0]             int_part;
  logic [AW-1:0]             idx0, idx1;
  logic [AEXT-1:0]           waddr_ext;
  logic [AW-1:0]             waddr;
  logic signed [DW-1:0]      diff;
  logic signed [PRW-1:0]     prod;
  logic [PRW-1:0]            biased;
  logic signed [PRW-1:0]     delta;
  logic signed [SW-1:0]      vi;
  logic signed [SCW-1:0]     contrib;
  logic signed [SUMW-1:0]    sum;
  logic signed [MW-1:0]      sat;

  always_comb begin
    len_eff     = (cfg.table_length == '0) ? wvm_pkg::LEN_W'(1) : cfg.table_length;
    end_phase   = EW'(len_eff - wvm_pkg::LEN_W'(1)) << FB;
    at_end      = CW'(phase_r) >= CW'(end_phase);
    wrap        = cfg.loop_enable && (phase_r >= cfg.loop_end_phase);
    eff_phase   = wrap ? cfg.loop_start_phase : phase_r;
    active_tick = active_r && (cfg.loop_enable || !at_end);
    int_part    = eff_phase >> FB;
    idx0        = int_part[AW-1:0];
    idx1        = idx0 + AW'(1);
    waddr_ext   = AEXT'(table_address);
    waddr       = waddr_ext[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      table_mem[waddr] <= table_sample;
    end
    if (cmd.tick) begin
      rd0_r <= table_mem[idx0];
      rd1_r <= table_mem[idx1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= '0;
      active_r <= 1'b0;
    end else if (cmd.start) begin
      phase_r  <= '0;
      active_r <= 1'b1;
    end else if (cmd.tick) begin
      active_r <= active_tick;
      if (active_tick) begin
        phase_r <= eff_phase + cfg.phase_increment;
      end
    end
  end

  always_comb begin
    diff    = DW'(rd1_r) - DW'(rd0_r);
    prod    = diff * $signed({1'b0, frac_r});
    biased  = prod_r[PRW-1] ? (prod_r + TRUNC_BIAS) : prod_r;
    delta   = $signed(biased) >>> FB;
    vi      = v_r + delta[SW-1:0];
    contrib = scaled_r >>> 15;
    sum     = SUMW'(mix_r) + SUMW'(contrib);
    if (sum > MIX_MAX) begin
      sat = MW'(MIX_MAX);
    end else if (sum < MIX_MIN) begin
      sat = MW'(MIX_MIN);
    end else begin
      sat = sum[MW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick) begin
      frac_r        <= eff_phase[FB-1:0];
      tick_active_r <= active_tick;
      mix_r         <= mix_in;
    end
    if (cmd.diff_en) begin
      prod_r <= prod;
      v_r    <= rd0_r;
    end
    if (cmd.interp_en) begin
      vi_r <= cfg.interp_enable ? vi : v_r;
    end
    if (cmd.scale_en) begin
      scaled_r <= $signed({1'b0, cfg.mix_gain}) * vi_r;
    end
    if (cmd.out_en) begin
      mix_out_r <= tick_active_r ? sat : mix_r;
      playing_r <= tick_active_r;
    end
  end

  assign mix_out = mix_out_r;
  assign playing = playing_r;

endmodule

`default_nettype wire

FILE: rtl/wavetable_voice_mixer_unit.sv
// ----------------------------------------------------------------------------
// wavetable_voice_mixer_unit
// One wavetable voice with linear interpolation, mixed into a 24-bit stream.
//
//   channel   direction  contents
//   in_ch     sink       action, table_address, table_sample, mix_in
//   out_ch    source     mix_out, playing (one result per tick)
//   cfg_*     write      seven registers, index 0..6
//
// Load and start items finish on acceptance. A tick runs through table read,
// difference times fraction, interpolation, gain multiply, saturating mix.
// The next item is taken while a result waits; a tick holds in its mix step
// until the output register is free. Reset is synchronous, clears the phase
// and the voice and sets register defaults; the sample table is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module wavetable_voice_mixer_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [wvm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [wvm_pkg::CFG_W-1:0]      cfg_data,
  wvm_in_if.sink                              in_ch,
  wvm_out_if.source                           out_ch
);

  wvm_pkg::cfg_t cfg;
  wvm_pkg::cmd_t cmd;

  wvm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  wvm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  wvm_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .cmd           (cmd),
    .table_address (in_ch.table_address),
    .table_sample  (in_ch.table_sample),
    .mix_in        (in_ch.mix_in),
    .mix_out       (out_ch.mix_out),
    .playing       (out_ch.playing)
  );

endmodule

`default_nettype wire
